// ===== rtl/core/qmac_pkg.sv =====
// ----------------------------------------------------------------------------
// qmac_pkg: shared types and constants for the quantized int8 mac unit
// opcodes and the payload structs that travel between pipeline stages
// ----------------------------------------------------------------------------
`default_nettype none

package qmac_pkg;

  localparam logic [1:0] OP_DOT8    = 2'd0;
  localparam logic [1:0] OP_MAC2    = 2'd1;
  localparam logic [1:0] OP_MAC4    = 2'd2;
  localparam logic [1:0] OP_REQUANT = 2'd3;

  // operand prep stage output
  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] acc;
    logic [63:0] opa;
    logic [63:0] opb;
    logic [31:0] x0;      // offset-corrected input, or biased accumulator
    logic [31:0] x1;      // offset-corrected second input
    logic [5:0]  shamt;   // total right shift, 1..63
  } s1_t;

  // multiply stage output
  typedef struct packed {
    logic [1:0]        op;
    logic [63:0]       acc;
    logic [23:0]       zq;     // zero point, min, max
    logic [5:0]        shamt;
    logic [63:0]       prod;
    logic [7:0][15:0]  dp;     // dot8 lane products
    logic [3:0][31:0]  term;   // mac terms: lo pair then hi pair
  } s2_t;

  // reduce stage output
  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] acc;
    logic [23:0] zq;
    logic [18:0] dsum;
    logic [31:0] lo_add;
    logic [31:0] hi_add;
    logic [31:0] scaled;
  } s3_t;

endpackage

`default_nettype wire

// ===== rtl/core/quantized_int8_mac_unit_core.sv =====
// datapath: four register stages from transaction accept to result_valid, the first
//   loaded at the accepting edge
// throughput: one transaction per cycle unless result_ready stalls the output, set
//   by the four register stages, each taking a new one when empty or passing its own on
// reset: rst clears all stage valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
// quantized_int8_mac_unit_core: quantized int8 mac function unit
// dot8, two-channel int8 mac, int4-filter mac and requantize, 4-stage pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module quantized_int8_mac_unit_core (
  input  wire logic                clk,
  input  wire logic                rst,
  // item channel
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire logic [1:0]          opcode,
  input  wire logic signed [63:0]  operand_one,
  input  wire logic [63:0]         operand_two,
  input  wire logic [63:0]         operand_three,
  // result channel
  output logic                     result_valid,
  input  wire logic                result_ready,
  output logic signed [63:0]       result_word
);

  // stage handshakes: each stage loads when it is empty or its downstream takes
  // its transaction, so bubbles are squeezed out while the output stalls
  logic          v1;
  logic          v2;
  logic          v3;
  logic          r2;
  logic          r3;
  logic          r4;
  qmac_pkg::s1_t d1;
  qmac_pkg::s2_t d2;
  qmac_pkg::s3_t d3;

  // stage 1: offset adds, requant bias add and shift saturation
  qmac_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (item_valid),
    .in_ready      (item_ready),
    .opcode        (opcode),
    .operand_one   (operand_one),
    .operand_two   (operand_two),
    .operand_three (operand_three),
    .out_valid     (v1),
    .out_ready     (r2),
    .out_data      (d1)
  );

  // stage 2: all multipliers (8x int8 lanes, 4 mac terms, 32x32 requant)
  qmac_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (r2),
    .in_data   (d1),
    .out_valid (v2),
    .out_ready (r3),
    .out_data  (d2)
  );

  // stage 3: lane sum, term pair sums, rounding arithmetic shift
  qmac_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (r3),
    .in_data   (d2),
    .out_valid (v3),
    .out_ready (r4),
    .out_data  (d3)
  );

  // stage 4: accumulate or zero point plus clamp, into the output register
  qmac_final u_final (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_ready  (r4),
    .in_data   (d3),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_word  (result_word)
  );

endmodule

`default_nettype wire

// ===== rtl/core/qmac_front.sv =====
// ----------------------------------------------------------------------------
// qmac_front: operand prep stage
// adds input offsets, biases the requantize accumulator, saturates the shift
// ----------------------------------------------------------------------------
`default_nettype none

module qmac_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          opcode,
  input  wire logic signed [63:0]  operand_one,
  input  wire logic [63:0]         operand_two,
  input  wire logic [63:0]         operand_three,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output qmac_pkg::s1_t            out_data
);

  logic          valid;
  qmac_pkg::s1_t data;
  qmac_pkg::s1_t data_next;

  logic [31:0]       off;
  logic signed [7:0] sh;
  logic signed [7:0] sh_sat;

  always_comb begin
    off    = operand_two[63:32];
    sh     = $signed(operand_three[31:24]);
    sh_sat = sh;
    if (sh < -8'sd32) sh_sat = -8'sd32;
    if (sh > 8'sd30)  sh_sat = 8'sd30;

    data_next.op    = opcode;
    data_next.acc   = operand_one;
    data_next.opa   = operand_two;
    data_next.opb   = operand_three;
    data_next.shamt = 6'(8'sd31 - sh_sat);
    case (opcode)
      qmac_pkg::OP_MAC4: begin
        data_next.x0 = {{24{operand_two[23]}}, operand_two[23:16]} + off;
        data_next.x1 = {{24{operand_two[31]}}, operand_two[31:24]} + off;
      end
      qmac_pkg::OP_REQUANT: begin
        data_next.x0 = operand_one[31:0] + operand_two[31:0];
        data_next.x1 = {{24{operand_three[15]}}, operand_three[15:8]} + off;
      end
      default: begin
        data_next.x0 = {{24{operand_three[7]}}, operand_three[7:0]} + off;
        data_next.x1 = {{24{operand_three[15]}}, operand_three[15:8]} + off;
      end
    endcase
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/qmac_mult.sv =====
// ----------------------------------------------------------------------------
// qmac_mult: multiply stage
// eight int8 lane products, four 32-bit mac terms and the 32x32 requant product
// ----------------------------------------------------------------------------
`default_nettype none

module qmac_mult (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  qmac_pkg::s1_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output qmac_pkg::s2_t out_data
);

  logic          valid;
  qmac_pkg::s2_t data;
  qmac_pkg::s2_t data_next;

  logic              is_mac4;
  logic [3:0][31:0]  f;
  logic [3:0][31:0]  x;

  always_comb begin
    is_mac4 = (in_data.op == qmac_pkg::OP_MAC4);

    // lo pair then hi pair; mac2 leaves the second term of each pair zero
    if (is_mac4) begin
      f[0] = {{28{in_data.opa[3]}},  in_data.opa[3:0]};
      f[1] = {{28{in_data.opa[11]}}, in_data.opa[11:8]};
      f[2] = {{28{in_data.opa[7]}},  in_data.opa[7:4]};
      f[3] = {{28{in_data.opa[15]}}, in_data.opa[15:12]};
      x[2] = in_data.x0;
    end else begin
      f[0] = {{24{in_data.opa[7]}},  in_data.opa[7:0]};
      f[1] = '0;
      f[2] = {{24{in_data.opa[15]}}, in_data.opa[15:8]};
      f[3] = '0;
      x[2] = in_data.x1;
    end
    x[0] = in_data.x0;
    x[1] = in_data.x1;
    x[3] = in_data.x1;

    data_next.op    = in_data.op;
    data_next.acc   = in_data.acc;
    data_next.zq    = in_data.opb[23:0];
    data_next.shamt = in_data.shamt;
    data_next.prod  = $signed(in_data.x0) * $signed(in_data.opa[63:32]);
    for (int i = 0; i < 8; i++) begin
      data_next.dp[i] = $signed(in_data.opa[8*i +: 8]) * $signed(in_data.opb[8*i +: 8]);
    end
    for (int j = 0; j < 4; j++) begin
      data_next.term[j] = f[j] * x[j];
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/qmac_reduce.sv =====
// ----------------------------------------------------------------------------
// qmac_reduce: reduce stage
// sums lane products and term pairs, applies the rounding right shift
// ----------------------------------------------------------------------------
`default_nettype none

module qmac_reduce (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  qmac_pkg::s2_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output qmac_pkg::s3_t out_data
);

  logic          valid;
  qmac_pkg::s3_t data;
  qmac_pkg::s3_t data_next;

  logic [18:0]        dsum;
  logic signed [63:0] shifted;
  logic               rnd;

  always_comb begin
    dsum = '0;
    for (int i = 0; i < 8; i++) begin
      dsum = dsum + {{3{in_data.dp[i][15]}}, in_data.dp[i]};
    end

    shifted = $signed(in_data.prod) >>> in_data.shamt;
    rnd     = in_data.prod[6'(in_data.shamt - 6'd1)];

    data_next.op     = in_data.op;
    data_next.acc    = in_data.acc;
    data_next.zq     = in_data.zq;
    data_next.dsum   = dsum;
    data_next.lo_add = in_data.term[0] + in_data.term[1];
    data_next.hi_add = in_data.term[2] + in_data.term[3];
    data_next.scaled = shifted[31:0] + {31'd0, rnd};
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/qmac_final.sv =====
// ----------------------------------------------------------------------------
// qmac_final: accumulate and clamp stage
// adds into the accumulator(s) or adds the zero point and clamps; output register
// ----------------------------------------------------------------------------
`default_nettype none

module qmac_final (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  qmac_pkg::s3_t     in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic signed [63:0] out_word
);

  logic              valid;
  logic [63:0]       word;
  logic [63:0]       word_next;

  logic signed [31:0] r;
  logic signed [31:0] mn;
  logic signed [31:0] mx;

  always_comb begin
    r  = $signed(in_data.scaled + {{24{in_data.zq[23]}}, in_data.zq[23:16]});
    mn = $signed({{24{in_data.zq[15]}}, in_data.zq[15:8]});
    mx = $signed({{24{in_data.zq[7]}}, in_data.zq[7:0]});
    if (r < mn) r = mn;
    if (r > mx) r = mx;

    unique case (in_data.op)
      qmac_pkg::OP_DOT8: begin
        word_next = in_data.acc + {{45{in_data.dsum[18]}}, in_data.dsum};
      end
      qmac_pkg::OP_MAC2, qmac_pkg::OP_MAC4: begin
        word_next = {in_data.acc[63:32] + in_data.hi_add,
                     in_data.acc[31:0] + in_data.lo_add};
      end
      qmac_pkg::OP_REQUANT: begin
        word_next = {{32{r[31]}}, r};
      end
      default: begin
        word_next = in_data.acc;
      end
    endcase
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_word  = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word <= word_next;
    end
  end

endmodule

`default_nettype wire

// ===== bench/mac_result_checker.sv =====
// ----------------------------------------------------------------------------
// mac_result_checker: result predictor and comparator for the quantized mac
// watches both channels, computes the expected word for every accepted
// transaction and compares each accepted result against the oldest one
// ----------------------------------------------------------------------------
module mac_result_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  logic [1:0]         opcode,
  input  logic signed [63:0] operand_one,
  input  logic [63:0]        operand_two,
  input  logic [63:0]        operand_three,
  input  logic               result_valid,
  input  logic               result_ready,
  input  logic signed [63:0] result_word,
  output int                 fail_count,
  output int                 results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0] expected_words[$];

  function automatic logic [31:0] widen8(logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [31:0] widen4(logic [3:0] v);
    return {{28{v[3]}}, v};
  endfunction

  function automatic logic [63:0] predict_mac_result(logic [1:0] op, logic [63:0] acc,
                                                     logic [63:0] opa, logic [63:0] opb);
    longint      dot_sum;
    longint      prod;
    longint      shifted;
    logic [63:0] prod_bits;
    logic [31:0] off;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] xa;
    logic [31:0] xb;
    logic [31:0] biased;
    logic [31:0] rounded;
    logic [31:0] zsum;
    int          i;
    int          shift_amt;
    int          rshift;
    int          lo_lim;
    int          hi_lim;
    int          clamped;
    off = opa[63:32];
    case (op)
      qmac_pkg::OP_DOT8: begin
        dot_sum = 0;
        for (i = 0; i < 8; i++) begin
          dot_sum += longint'($signed(opa[8*i +: 8])) * longint'($signed(opb[8*i +: 8]));
        end
        return acc + dot_sum;
      end
      qmac_pkg::OP_MAC2: begin
        lo = acc[31:0] + widen8(opa[7:0]) * (widen8(opb[7:0]) + off);
        hi = acc[63:32] + widen8(opa[15:8]) * (widen8(opb[15:8]) + off);
        return {hi, lo};
      end
      qmac_pkg::OP_MAC4: begin
        xa = widen8(opa[23:16]) + off;
        xb = widen8(opa[31:24]) + off;
        lo = acc[31:0] + widen4(opa[3:0]) * xa + widen4(opa[11:8]) * xb;
        hi = acc[63:32] + widen4(opa[7:4]) * xa + widen4(opa[15:12]) * xb;
        return {hi, lo};
      end
      default: begin
        biased = acc[31:0] + opa[31:0];
        prod = longint'($signed(biased)) * longint'($signed(opa[63:32]));
        prod_bits = prod;
        shift_amt = $signed(opb[31:24]);
        if (shift_amt < -32) shift_amt = -32;
        if (shift_amt > 30) shift_amt = 30;
        rshift = 31 - shift_amt;
        shifted = prod >>> rshift;
        // round half up by adding the last bit shifted out
        rounded = shifted[31:0] + prod_bits[rshift-1];
        zsum = rounded + widen8(opb[23:16]);
        clamped = $signed(zsum);
        lo_lim = $signed(opb[15:8]);
        hi_lim = $signed(opb[7:0]);
        if (clamped < lo_lim) clamped = lo_lim;
        if (clamped > hi_lim) clamped = hi_lim;
        return longint'(clamped);
      end
    endcase
  endfunction

  initial begin
    fail_count = 0;
    results_pending = 0;
  end

  // results are checked before new transactions are queued, so a result
  // can never match the transaction accepted at the same edge
  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (expected_words.size() == 0) begin
          $error("result_word: unexpected result %h", result_word);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (result_word !== want) begin
            $error("result_word mismatch: expected %h, actual %h", want, result_word);
            fail_count++;
          end
        end
      end
      if (item_valid && item_ready) begin
        expected_words.push_back(predict_mac_result(opcode, operand_one,
                                                    operand_two, operand_three));
      end
      results_pending = expected_words.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the quantized int8 mac unit
// directed corner transactions for every opcode, then random transactions in
// four flow-control phases; checking is done by mac_result_checker
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PER_PHASE = 400;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  logic [1:0]         opcode = qmac_pkg::OP_DOT8;
  logic signed [63:0] operand_one = '0;
  logic [63:0]        operand_two = '0;
  logic [63:0]        operand_three = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic signed [63:0] result_word;

  int fail_count;
  int results_pending;

  // percentages of cycles in which the sender idles / the receiver stalls
  int send_idle_pct = 0;
  int stall_pct = 0;

  quantized_int8_mac_unit_core dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .opcode        (opcode),
    .operand_one   (operand_one),
    .operand_two   (operand_two),
    .operand_three (operand_three),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result_word   (result_word)
  );

  mac_result_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .opcode          (opcode),
    .operand_one     (operand_one),
    .operand_two     (operand_two),
    .operand_three   (operand_three),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result_word     (result_word),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #4ms;
    $display("FAILURE");
    $finish;
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    result_ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  // one transaction: optional idle gap, then hold valid until accepted;
  // always entered and left at a falling edge
  task automatic issue_op(logic [1:0] op, logic [63:0] a1, logic [63:0] a2,
                          logic [63:0] a3);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid    <= 1'b1;
    opcode        <= op;
    operand_one   <= a1;
    operand_two   <= a2;
    operand_three <= a3;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  // sender holds off until every expected result has come back
  task automatic drain_results();
    item_valid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
  endtask

  // byte-wise mix of the int8 extremes and random bytes, or a plain random word
  function automatic logic [63:0] pick_operand();
    logic [63:0] w;
    int i;
    if ($urandom_range(3) == 0) begin
      w = {$urandom, $urandom};
    end else begin
      for (i = 0; i < 8; i++) begin
        case ($urandom_range(5))
          0: w[8*i +: 8] = 8'h00;
          1: w[8*i +: 8] = 8'h7F;
          2: w[8*i +: 8] = 8'h80;
          3: w[8*i +: 8] = 8'hFF;
          default: w[8*i +: 8] = 8'($urandom_range(255));
        endcase
      end
    end
    return w;
  endfunction

  // requantize field bytes: {ignored, shift, zero point, min, max}
  function automatic logic [63:0] pick_requant_params();
    logic [7:0] shift_b;
    logic [7:0] zp_b;
    logic [7:0] min_b;
    logic [7:0] max_b;
    // mostly realistic shifts, sometimes anything (saturation path)
    if ($urandom_range(4) == 0) shift_b = 8'($urandom_range(255));
    else shift_b = 8'($urandom_range(0, 50) - 32);
    zp_b = 8'($urandom_range(255));
    // usually a proper window, sometimes inverted or random
    if ($urandom_range(4) == 0) begin
      min_b = 8'($urandom_range(255));
      max_b = 8'($urandom_range(255));
    end else begin
      min_b = 8'(-$urandom_range(0, 128));
      max_b = 8'($urandom_range(0, 127));
    end
    return {$urandom, shift_b, zp_b, min_b, max_b};
  endfunction

  task automatic issue_random_op();
    logic [1:0]  op;
    logic [63:0] a2;
    op = 2'($urandom_range(3));
    if (op == qmac_pkg::OP_REQUANT) begin
      a2 = pick_operand();
      // typical q31 multipliers most of the time
      if ($urandom_range(2) != 0) a2[63:32] = 32'h4000_0000 | 32'($urandom_range(32'h3FFF_FFFF));
      issue_op(op, pick_operand(), a2, pick_requant_params());
    end else begin
      issue_op(op, pick_operand(), pick_operand(), pick_operand());
    end
  endtask

  initial begin
    int ph;
    int n;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed corners, no idling
    // dot8: largest positive lane sum, mixed extremes, 64-bit wrap
    issue_op(qmac_pkg::OP_DOT8, 64'h0, 64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080);
    issue_op(qmac_pkg::OP_DOT8, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7F7F_7F7F_7F7F_7F7F,
             64'h8080_8080_8080_8080);
    issue_op(qmac_pkg::OP_DOT8, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0101_0101_0101_0101,
             64'h0101_0101_0101_0101);
    issue_op(qmac_pkg::OP_DOT8, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
             64'h0101_0101_0101_0101);
    // two-channel mac: extreme offsets, int32 wrap, unused bits set
    issue_op(qmac_pkg::OP_MAC2, 64'h7FFF_FFFF_8000_0000, 64'hFFFF_FFFF_ABCD_807F,
             64'hDEAD_BEEF_1234_7F80);
    issue_op(qmac_pkg::OP_MAC2, 64'h0, 64'h8000_0000_0000_8080, 64'h0000_0000_0000_8080);
    issue_op(qmac_pkg::OP_MAC2, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_7F7F,
             64'hFFFF_FFFF_FFFF_7F7F);
    // int4-filter mac: filters at -8 and 7, operand three ignored
    issue_op(qmac_pkg::OP_MAC4, 64'h0, 64'h7FFF_FFFF_807F_8888, 64'hFFFF_FFFF_FFFF_FFFF);
    issue_op(qmac_pkg::OP_MAC4, 64'h8000_0000_7FFF_FFFF, 64'h8000_0000_8080_7777, 64'h0);
    issue_op(qmac_pkg::OP_MAC4, 64'h1234_5678_9ABC_DEF0, 64'hFFFF_FFFF_7F80_8F7F,
             64'h5555_5555_AAAA_AAAA);
    // requantize: shift saturated low and high, exact limits
    issue_op(qmac_pkg::OP_REQUANT, 64'hFFFF_FFFF_0000_1000, 64'h7FFF_FFFF_0000_0000,
             64'h0000_0000_8000_807F);
    issue_op(qmac_pkg::OP_REQUANT, 64'h0000_0000_0000_0003, 64'h0000_0001_0000_0000,
             64'hFFFF_FFFF_7F00_807F);
    issue_op(qmac_pkg::OP_REQUANT, 64'h0, 64'h0000_0001_0000_0003,
             64'h0000_0000_1E00_807F);
    issue_op(qmac_pkg::OP_REQUANT, 64'h0, 64'h0000_0001_FFFF_FFFD,
             64'h0000_0000_1E00_807F);
    issue_op(qmac_pkg::OP_REQUANT, 64'h0000_0000_7FFF_FFFF, 64'h7FFF_FFFF_0000_0000,
             64'h0000_0000_E000_807F);
    // most positive product: both operands at -2^31
    issue_op(qmac_pkg::OP_REQUANT, 64'h0000_0000_8000_0000, 64'h8000_0000_0000_0000,
             64'h0000_0000_0000_807F);
    issue_op(qmac_pkg::OP_REQUANT, 64'h0000_0000_8000_0000, 64'h8000_0000_0000_0000,
             64'h0000_0000_1E00_807F);
    // min above max: max wins
    issue_op(qmac_pkg::OP_REQUANT, 64'h0000_0000_0000_0100, 64'h4000_0000_0000_0000,
             64'h0000_0000_0000_32F6);
    // zero point pushes across the int32 wrap, upper acc bits ignored
    issue_op(qmac_pkg::OP_REQUANT, 64'hAAAA_AAAA_7FFF_FF00, 64'h7FFF_FFFF_0000_00FF,
             64'h0000_0000_007F_807F);
    issue_op(qmac_pkg::OP_REQUANT, 64'h5555_5555_8000_0000, 64'h7FFF_FFFF_0000_0000,
             64'h0000_0000_FF80_807F);
    // all zeros, every opcode
    issue_op(qmac_pkg::OP_DOT8, 64'h0, 64'h0, 64'h0);
    issue_op(qmac_pkg::OP_MAC2, 64'h0, 64'h0, 64'h0);
    issue_op(qmac_pkg::OP_MAC4, 64'h0, 64'h0, 64'h0);
    issue_op(qmac_pkg::OP_REQUANT, 64'h0, 64'h0, 64'h0);
    drain_results();

    // random transactions across the flow-control phases
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 68; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 68; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) issue_random_op();
      drain_results();
    end

    // idle with the receiver never stalled to catch any stray result
    stall_pct = 0;
    repeat (12) @(negedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== quantized_int8_mac_unit_core.f =====
rtl/core/qmac_pkg.sv
rtl/core/qmac_front.sv
rtl/core/qmac_mult.sv
rtl/core/qmac_reduce.sv
rtl/core/qmac_final.sv
rtl/core/quantized_int8_mac_unit_core.sv
bench/mac_result_checker.sv
bench/testbench.sv
